// ===== hdl/slxfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slxfd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Largest audio frame that may produce results.
    localparam int MAX_RESULTS = 64;
    localparam int JOB_LEN_W   = 7;

    localparam logic [1:0] KIND_WAKEUP  = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_AUDIO   = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [2:0] REG_WAKEUP  = 3'd0;
    localparam logic [2:0] REG_COMMAND = 3'd1;
    localparam logic [2:0] REG_AUDIO   = 3'd2;
    localparam logic [2:0] REG_STATUS  = 3'd3;
    localparam logic [2:0] REG_ENABLE  = 3'd4;

    typedef struct packed {
        logic [7:0] wakeup_code;
        logic [7:0] command_code;
        logic [7:0] audio_code;
        logic [7:0] status_code;
        logic [3:0] enable;
    } t_cfg;

    // One finished frame handed from the parser to the result sequencer.
    typedef struct packed {
        logic [1:0]           kind;
        logic [JOB_LEN_W-1:0] count;
        logic [15:0]          value;
    } t_job;

    typedef struct packed {
        logic store_busy;
        logic q_full;
    } t_front_hold;

endpackage
`default_nettype wire

// ===== hdl/slxfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slxfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/slxfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slxfd_queue
    import slxfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/slxfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slxfd_front
    import slxfd_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cfg                           i_cfg,
    input  wire t_front_hold                    i_hold,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [7:0]                     i_byte,
    output logic                                o_push,
    output t_job                                o_job,
    output logic                                o_wr_en,
    output logic      [$clog2(STORE_DEPTH)-1:0] o_wr_addr,
    output logic      [7:0]                     o_wr_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_LENHI = 3'd3;
    localparam logic [2:0] PH_LENLO = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_type,   n_type;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count,  n_count;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_b0,     n_b0;
    logic [7:0]  r_b1,     n_b1;

    logic accept;
    logic frame_ok;
    t_job job;

    // Body bytes wait while the sequencer may still read the body store.
    assign o_ready = !((r_phase == PH_BODY && i_hold.store_busy) ||
                       (r_phase == PH_CHECK && i_hold.q_full));
    assign accept  = i_valid && o_ready;

    assign o_wr_addr = r_count[ADDR_W-1:0];
    assign o_wr_data = i_byte;
    assign o_wr_en   = accept && (r_phase == PH_BODY) && (r_count < 16'(STORE_DEPTH));

    // Classify the frame; the first matching type code wins.
    always_comb begin
        frame_ok   = 1'b0;
        job.kind   = KIND_WAKEUP;
        job.count  = JOB_LEN_W'(1);
        job.value  = {r_b0, r_b1};
        if (r_type == i_cfg.wakeup_code) begin
            frame_ok = i_cfg.enable[0] && (r_length == 16'd2);
        end else if (r_type == i_cfg.command_code) begin
            job.kind = KIND_COMMAND;
            frame_ok = i_cfg.enable[1] && (r_length == 16'd2);
        end else if (r_type == i_cfg.audio_code) begin
            job.kind  = KIND_AUDIO;
            job.count = r_length[JOB_LEN_W-1:0];
            frame_ok  = i_cfg.enable[2] && (r_length != 16'd0) &&
                        (r_length <= 16'(STORE_DEPTH));
        end else if (r_type == i_cfg.status_code) begin
            job.kind  = KIND_STATUS;
            job.value = {8'h00, r_b0};
            frame_ok  = i_cfg.enable[3] && (r_length == 16'd1);
        end
    end

    assign o_job  = job;
    assign o_push = accept && (r_phase == PH_CHECK) && (i_byte == r_xor) && frame_ok;

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_length = r_length;
        n_count  = r_count;
        n_xor    = r_xor;
        n_b0     = r_b0;
        n_b1     = r_b1;
        if (accept) begin
            unique case (r_phase)
                PH_SYNC2: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_xor   = SYNC_FIRST ^ SYNC_SECOND;
                        n_phase = PH_TYPE;
                    end else if (i_byte != SYNC_FIRST) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_phase = PH_LENHI;
                end
                PH_LENHI: begin
                    n_length = {i_byte, 8'h00};
                    n_xor    = r_xor ^ i_byte;
                    n_phase  = PH_LENLO;
                end
                PH_LENLO: begin
                    n_length = {r_length[15:8], i_byte};
                    n_xor    = r_xor ^ i_byte;
                    n_count  = 16'd0;
                    n_phase  = ({r_length[15:8], i_byte} == 16'd0) ? PH_CHECK : PH_BODY;
                end
                PH_BODY: begin
                    if (r_count == 16'd0) begin
                        n_b0 = i_byte;
                    end
                    if (r_count == 16'd1) begin
                        n_b1 = i_byte;
                    end
                    n_xor   = r_xor ^ i_byte;
                    n_count = r_count + 16'd1;
                    if (n_count >= r_length) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_xor   = 8'h00;
                    n_count = 16'd0;
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_type   <= 8'h00;
            r_length <= 16'd0;
            r_count  <= 16'd0;
            r_xor    <= 8'h00;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
            r_xor    <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= n_b0;
        r_b1 <= n_b1;
    end

endmodule
`default_nettype wire

// ===== hdl/slxfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slxfd_back
    import slxfd_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_empty,
    input  wire t_job                           i_job,
    output logic                                o_pop,
    output logic                                o_busy,
    output logic                                o_rd_en,
    output logic      [$clog2(STORE_DEPTH)-1:0] o_rd_addr,
    input  wire logic [7:0]                     i_rd_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [1:0]                     o_kind,
    output logic      [15:0]                    o_value,
    output logic                                o_last
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_ONE  = 2'd1;
    localparam logic [1:0] BK_READ = 2'd2;
    localparam logic [1:0] BK_DATA = 2'd3;

    logic [1:0]        r_state, n_state;
    t_job              r_job,   n_job;
    logic [ADDR_W-1:0] r_idx,   n_idx;
    logic              r_valid, n_valid;
    logic [1:0]        r_kind,  n_kind;
    logic [15:0]       r_value, n_value;
    logic              r_last,  n_last;
    logic              out_free;
    logic              idx_last;

    assign out_free  = !r_valid || i_ready;
    assign idx_last  = (JOB_LEN_W'(r_idx) == (r_job.count - JOB_LEN_W'(1)));
    assign o_busy    = (r_state != BK_IDLE);
    assign o_rd_addr = r_idx;
    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_value   = r_value;
    assign o_last    = r_last;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_kind  = r_kind;
        n_value = r_value;
        n_last  = r_last;
        o_pop   = 1'b0;
        o_rd_en = 1'b0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_idx   = '0;
                    n_state = (i_job.kind == KIND_AUDIO) ? BK_READ : BK_ONE;
                end
            end
            BK_ONE: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_kind  = r_job.kind;
                    n_value = r_job.value;
                    n_last  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            BK_READ: begin
                o_rd_en = 1'b1;
                n_state = BK_DATA;
            end
            BK_DATA: begin
                // The read data holds until the next read is issued.
                if (out_free) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_AUDIO;
                    n_value = {8'h00, i_rd_data};
                    n_last  = idx_last;
                    if (idx_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_last  <= n_last;
    end

endmodule
`default_nettype wire

// ===== hdl/sync_length_xor_frame_decoder_top.sv =====
// Frame decoder for a received serial byte stream.
// The s_ channel takes one received byte per item. The parser hunts for the
// sync pair 0xAA 0x55, reads type, big-endian length, body and an XOR
// checksum, and hands each good, enabled frame to a result sequencer through
// a two-entry queue. The m_ channel gives one item per result: the value in
// tdata, the kind in tuser and the final result of a frame marked by tlast.
// Header and length bytes are never held; the checksum byte waits while the
// queue is full. Body bytes are taken one per cycle while the sequencer is
// idle and the queue empty; while an earlier frame may still read the body
// store they wait. An id or status result passes through the queue and the
// sequencer into the output register; each audio result takes a store read
// and an output load. When the receiver holds m_tready low the output
// register holds its item and the sequencer, then the parser, stall behind it.
// Reset clears the parser to hunting, empties the queue and restores the
// type code and enable registers, written through the APB port at 4*index.
`timescale 1ns / 1ps
`default_nettype none
module sync_length_xor_frame_decoder_top
    import slxfd_pkg::*;
#(
    parameter int BODY_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] event_value
    output logic      [1:0]  m_tuser,   // [1:0] event_kind
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int STORE_DEPTH = (BODY_DEPTH < MAX_RESULTS) ? BODY_DEPTH : MAX_RESULTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    t_cfg              r_cfg;
    t_front_hold       hold;
    t_job              push_job;
    t_job              head_job;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              back_busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wakeup_code  <= 8'd1;
            r_cfg.command_code <= 8'd2;
            r_cfg.audio_code   <= 8'd3;
            r_cfg.status_code  <= 8'd4;
            r_cfg.enable       <= 4'hF;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_WAKEUP:  r_cfg.wakeup_code  <= pwdata[7:0];
                REG_COMMAND: r_cfg.command_code <= pwdata[7:0];
                REG_AUDIO:   r_cfg.audio_code   <= pwdata[7:0];
                REG_STATUS:  r_cfg.status_code  <= pwdata[7:0];
                REG_ENABLE:  r_cfg.enable       <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_WAKEUP:  prdata = {24'h0, r_cfg.wakeup_code};
            REG_COMMAND: prdata = {24'h0, r_cfg.command_code};
            REG_AUDIO:   prdata = {24'h0, r_cfg.audio_code};
            REG_STATUS:  prdata = {24'h0, r_cfg.status_code};
            REG_ENABLE:  prdata = {28'h0, r_cfg.enable};
            default:     prdata = 32'h0;
        endcase
    end

    assign hold.store_busy = back_busy || !q_empty;
    assign hold.q_full     = q_full;

    slxfd_front #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_hold   (hold),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_byte   (s_tdata),
        .o_push   (push),
        .o_job    (push_job),
        .o_wr_en  (wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data)
    );

    slxfd_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    slxfd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (pop),
        .o_job  (head_job),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    slxfd_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_busy   (back_busy),
        .o_rd_en  (rd_en),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_kind   (m_tuser),
        .o_value  (m_tdata),
        .o_last   (m_tlast)
    );

`ifndef SYNTHESIS
    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !back_busy && q_empty)
        else $error("body store written while the sequencer may read it");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("frame queued into a full queue");

    a_only_audio_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == KIND_AUDIO))
        else $error("non-audio result without last flag");

    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty && !back_busy)
        else $error("queue popped while empty or sequencer busy");
`endif

endmodule
`default_nettype wire

// ===== test/sync_length_xor_frame_decoder_top_tb.sv =====
`timescale 1ns / 1ps
module sync_length_xor_frame_decoder_top_tb;
    import slxfd_pkg::*;

    localparam int BODY_DEPTH   = 64;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;

    typedef enum logic [2:0] {
        SEEK_SYNC1, SEEK_SYNC2, READ_TYPE, READ_LEN_HI, READ_LEN_LO, READ_BODY, READ_CHECK
    } t_parse_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        last;
    } t_decoded_event;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Register copy, at reset values.
    logic [7:0] code_wakeup  = 8'd1;
    logic [7:0] code_command = 8'd2;
    logic [7:0] code_audio   = 8'd3;
    logic [7:0] code_status  = 8'd4;
    logic [3:0] kind_mask    = 4'hF;

    // Parser copy.
    t_parse_state parse_state  = SEEK_SYNC1;
    logic [7:0]   frame_type_q = 8'h00;
    logic [15:0]  frame_len    = 16'h0000;
    logic [15:0]  body_seen    = 16'h0000;
    logic [7:0]   frame_xor    = 8'h00;
    logic [7:0]   body_bytes [BODY_DEPTH];

    t_decoded_event pending_events [$];
    t_decoded_event oldest_event;
    logic [7:0]     body_fill [$];

    int failures     = 0;
    int bytes_sent   = 0;
    int idle_cycles  = 0;
    int rx_hold_left = 0;
    bit tx_no_gaps   = 1'b0;
    bit rx_free_run  = 1'b0;
    bit rx_long_hold = 1'b0;

    sync_length_xor_frame_decoder_top #(
        .BODY_DEPTH(BODY_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_event(input logic [1:0] kind, input logic [15:0] value,
                                       input logic last);
        t_decoded_event ev;
        ev.kind  = kind;
        ev.value = value;
        ev.last  = last;
        pending_events.push_back(ev);
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        int n;
        case (parse_state)
            SEEK_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    frame_xor   = SYNC_FIRST ^ SYNC_SECOND;
                    parse_state = READ_TYPE;
                end else if (b != SYNC_FIRST) begin
                    parse_state = SEEK_SYNC1;
                end
            end
            READ_TYPE: begin
                frame_type_q = b;
                frame_xor    = frame_xor ^ b;
                parse_state  = READ_LEN_HI;
            end
            READ_LEN_HI: begin
                frame_len   = {b, 8'h00};
                frame_xor   = frame_xor ^ b;
                parse_state = READ_LEN_LO;
            end
            READ_LEN_LO: begin
                frame_len[7:0] = b;
                frame_xor      = frame_xor ^ b;
                body_seen      = 16'h0000;
                parse_state    = (frame_len == 16'h0000) ? READ_CHECK : READ_BODY;
            end
            READ_BODY: begin
                // Bytes past the store still count toward length and checksum.
                if (body_seen < BODY_DEPTH) body_bytes[body_seen[5:0]] = b;
                frame_xor = frame_xor ^ b;
                body_seen = body_seen + 16'd1;
                if (body_seen >= frame_len) parse_state = READ_CHECK;
            end
            READ_CHECK: begin
                if (b == frame_xor) begin
                    // The first matching code decides the kind, even when disabled.
                    if (frame_type_q == code_wakeup) begin
                        if (kind_mask[0] && frame_len == 16'd2)
                            push_event(KIND_WAKEUP, {body_bytes[0], body_bytes[1]}, 1'b1);
                    end else if (frame_type_q == code_command) begin
                        if (kind_mask[1] && frame_len == 16'd2)
                            push_event(KIND_COMMAND, {body_bytes[0], body_bytes[1]}, 1'b1);
                    end else if (frame_type_q == code_audio) begin
                        if (kind_mask[2] && frame_len >= 1 && frame_len <= BODY_DEPTH
                            && frame_len <= MAX_RESULTS) begin
                            for (n = 0; n < frame_len; n++)
                                push_event(KIND_AUDIO, {8'h00, body_bytes[n[5:0]]},
                                           n == frame_len - 1);
                        end
                    end else if (frame_type_q == code_status) begin
                        if (kind_mask[3] && frame_len == 16'd1)
                            push_event(KIND_STATUS, {8'h00, body_bytes[0]}, 1'b1);
                    end
                end
                frame_xor   = 8'h00;
                body_seen   = 16'h0000;
                parse_state = SEEK_SYNC1;
            end
            default: begin
                parse_state = (b == SYNC_FIRST) ? SEEK_SYNC2 : SEEK_SYNC1;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
        predict_byte(b);
    endtask

    // Body bytes come from body_fill first, then at random.
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                              input bit corrupt);
        logic [7:0] cs;
        logic [7:0] b;
        int i;
        cs = SYNC_FIRST ^ SYNC_SECOND ^ ftype ^ flen[15:8] ^ flen[7:0];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(ftype);
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        for (i = 0; i < flen; i++) begin
            if (i < body_fill.size()) b = body_fill[i];
            else b = 8'($urandom_range(0, 255));
            cs = cs ^ b;
            send_byte(b);
        end
        body_fill.delete();
        if (corrupt) cs = cs ^ 8'($urandom_range(1, 255));
        send_byte(cs);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WAKEUP:  code_wakeup  = value[7:0];
            REG_COMMAND: code_command = value[7:0];
            REG_AUDIO:   code_audio   = value[7:0];
            REG_STATUS:  code_status  = value[7:0];
            REG_ENABLE:  kind_mask    = value[3:0];
            default: ;
        endcase
    endtask

    // Upper bits of each write carry junk that the block must drop.
    task automatic set_config(input logic [7:0] w, input logic [7:0] c, input logic [7:0] a,
                              input logic [7:0] s, input logic [3:0] m);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_WAKEUP, {junk[31:8], w});
        junk = $urandom;
        write_reg(REG_COMMAND, {junk[31:8], c});
        junk = $urandom;
        write_reg(REG_AUDIO, {junk[31:8], a});
        junk = $urandom;
        write_reg(REG_STATUS, {junk[31:8], s});
        junk = $urandom;
        write_reg(REG_ENABLE, {junk[31:4], m});
    endtask

    task automatic run_random_traffic(input int n_bytes);
        int start;
        int r;
        logic [7:0]  ftype;
        logic [7:0]  x;
        logic [15:0] flen;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                x = 8'($urandom_range(0, 255));
                if (x == SYNC_FIRST) x = 8'h00;
                send_byte(x);
            end else if (r < 11) begin
                // A sync byte followed by something that breaks the pair.
                x = 8'($urandom_range(0, 255));
                if (x == SYNC_FIRST || x == SYNC_SECOND) x = 8'h00;
                send_byte(SYNC_FIRST);
                send_byte(x);
            end else if (r < 14) begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_FIRST);
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        ftype = code_wakeup;
                        flen  = ($urandom_range(0, 9) < 8) ? 16'd2
                                                           : 16'($urandom_range(0, 3));
                    end
                    1: begin
                        ftype = code_command;
                        flen  = ($urandom_range(0, 9) < 8) ? 16'd2
                                                           : 16'($urandom_range(0, 3));
                    end
                    2: begin
                        ftype = code_audio;
                        flen  = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(1, 8))
                                                           : 16'($urandom_range(0, 20));
                    end
                    3: begin
                        ftype = code_status;
                        flen  = ($urandom_range(0, 9) < 8) ? 16'd1
                                                           : 16'($urandom_range(0, 3));
                    end
                    default: begin
                        ftype = 8'($urandom_range(0, 255));
                        flen  = 16'($urandom_range(0, 4));
                    end
                endcase
                send_frame(ftype, flen, $urandom_range(0, 9) == 0);
            end
        end
        wait_idle();
    endtask

    task automatic test_frame_kinds();
        body_fill = '{8'hFF, 8'hFF};
        send_frame(code_wakeup, 16'd2, 1'b0);
        body_fill = '{8'h00, 8'h00};
        send_frame(code_command, 16'd2, 1'b0);
        body_fill = '{8'hFF};
        send_frame(code_status, 16'd1, 1'b0);
        body_fill = '{8'h00};
        send_frame(code_audio, 16'd1, 1'b0);
        wait_idle();
    endtask

    task automatic test_special_cases();
        // A doubled first sync byte still leads into the frame.
        send_byte(SYNC_FIRST);
        send_frame(code_status, 16'd1, 1'b0);
        send_byte(SYNC_FIRST);
        send_byte(8'h12);
        send_frame(code_audio, 16'd0, 1'b0);
        send_frame(code_wakeup, 16'd2, 1'b1);
        send_frame(code_status, 16'd2, 1'b0);
        send_frame(8'h99, 16'd1, 1'b0);
        send_frame(code_command, 16'd2, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        rx_long_hold = 1'b1;
        tx_no_gaps   = 1'b1;
        // The longest audio frame, then one past the store, then a short frame
        // that piles up behind the held output.
        send_frame(code_audio, 16'd64, 1'b0);
        send_frame(code_audio, 16'd65, 1'b0);
        send_frame(code_command, 16'd2, 1'b0);
        tx_no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_register_settings();
        run_random_traffic(10);
        set_config(8'h00, 8'hFF, 8'h80, 8'h7F, 4'hF);
        run_random_traffic(10);
        // Shared codes: the earlier kind wins, and here it is disabled.
        set_config(8'h33, 8'h33, 8'h44, 8'h44, 4'hA);
        run_random_traffic(10);
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 4'h0);
        run_random_traffic(8);
        set_config(8'h5A, 8'hA5, 8'h0F, 8'hF0, 4'hF);
        tx_no_gaps  = 1'b1;
        rx_free_run = 1'b1;
        run_random_traffic(12);
        tx_no_gaps  = 1'b0;
        rx_free_run = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left == 0 && rx_long_hold) begin
            rx_long_hold = 1'b0;
            rx_hold_left = LONG_HOLD;
        end else if (rx_hold_left == 0 && !rx_free_run) begin
            rx_hold_left = pick_gap();
        end
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected item: value %h kind %0d last %0b", m_tdata, m_tuser,
                       m_tlast);
                failures++;
            end else begin
                oldest_event = pending_events.pop_front();
                if (m_tuser !== oldest_event.kind) begin
                    $error("event_kind: expected %0d, got %0d", oldest_event.kind, m_tuser);
                    failures++;
                end
                if (m_tdata !== oldest_event.value) begin
                    $error("event_value: expected %h, got %h", oldest_event.value, m_tdata);
                    failures++;
                end
                if (m_tlast !== oldest_event.last) begin
                    $error("last_of_frame: expected %0b, got %0b", oldest_event.last,
                           m_tlast);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_frame_kinds();
        test_special_cases();
        test_backpressure();
        test_register_settings();
        if (pending_events.size() != 0) begin
            $error("%0d expected items never arrived", pending_events.size());
            failures++;
        end
        if (failures == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

// ===== sync_length_xor_frame_decoder_top.f =====
hdl/slxfd_pkg.sv
hdl/slxfd_ram.sv
hdl/slxfd_queue.sv
hdl/slxfd_front.sv
hdl/slxfd_back.sv
hdl/sync_length_xor_frame_decoder_top.sv
test/sync_length_xor_frame_decoder_top_tb.sv
